/* rtl/vqnc_pkg.sv */
// ----------------------------------------------------------------------------
// vqnc_pkg
// Shared types and constants for the nearest-code vector quantiser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vqnc_pkg;

    // Fixed field widths of the channels
    localparam int CODE_W     = 8;
    localparam int FIDX_W     = 4;
    localparam int SAMPLE_W   = 16;
    localparam int DIST_W     = 18;
    localparam int CODES_CFG_W = 9;
    localparam int FEATS_CFG_W = 5;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_IDX_W   = 1;

    // Feature positions reachable through the feature index field
    localparam int FEAT_IDX_LIM = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CODES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATS = 1'b1;

    // Configuration reset values
    localparam logic [CODES_CFG_W-1:0] CODES_RESET = 9'd256;
    localparam logic [FEATS_CFG_W-1:0] FEATS_RESET = 5'd16;

    // Input operation codes
    localparam logic OP_CODE_WR = 1'b0;
    localparam logic OP_OBSERVE = 1'b1;

    // Command kinds passed from the front part to the back part
    localparam logic [1:0] KIND_CODE_WR = 2'd0;
    localparam logic [1:0] KIND_OBS     = 2'd1;
    localparam logic [1:0] KIND_SEARCH  = 2'd2;

    // Command queue depth (power of two)
    localparam int CMD_FIFO_DEPTH = 4;

    typedef struct packed {
        logic                       op;
        logic [CODE_W-1:0]          code_index;
        logic [FIDX_W-1:0]          feature_index;
        logic signed [SAMPLE_W-1:0] sample_value;
    } t_in;

    typedef struct packed {
        logic [CODE_W-1:0] best_code;
        logic [DIST_W-1:0] distance;
    } t_out;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [CODE_W-1:0]          code_index;
        logic [FIDX_W-1:0]          feature_index;
        logic signed [SAMPLE_W-1:0] sample_value;
    } t_cmd;

endpackage

/* rtl/vector_quantizer_nearest_code_unit.sv */
// ----------------------------------------------------------------------------
// vector_quantizer_nearest_code_unit
// Nearest-codeword vector quantiser, squared Euclidean distance.
//
// Input channel (i_valid / o_stall, payload i_data): op 0 transactions write
// one codebook feature, op 1 transactions supply one observation feature.
// The op 1 transaction at feature position features_in_use-1 starts a search
// over codes 0..codes_in_use-1; one result transaction (best code, floor
// square root of its summed squared difference) then leaves on the output
// channel (o_valid / i_stall, payload o_data). Ties keep the earlier code.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 codes_in_use, 1 features_in_use); the user must write it only while
// the unit is idle, which the unit itself does not enforce. Every
// transaction is queued and then executed in the back part; a search makes
// one codebook read and one multiply-accumulate per cycle through the
// single RAM read port, then drains its pipeline and takes a bit-serial
// square root of the best sum.
// Reset clears control state and restores the register defaults; the
// codebook and observation buffer hold nothing defined until written.
// A stalled receiver holds the result in the output register; the queue
// keeps taking input until it fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_quantizer_nearest_code_unit #(
    parameter int MAX_CODES    = 256,
    parameter int MAX_FEATURES = 16,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  vqnc_pkg::t_in                     i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output vqnc_pkg::t_out                    o_data,
    input  logic                              i_cfg_we,
    input  logic [vqnc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vqnc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import vqnc_pkg::*;

    // exact per-code sums, saturated to 64 bits as the compare width
    localparam int ACC_BITS = 2 * SAMPLE_BITS + 4;
    localparam int SUM_BITS = ACC_BITS > 64 ? 64 : ACC_BITS;

    // effective register limits
    localparam int CODE_LIM = MAX_CODES < 511 ? MAX_CODES : 511;
    localparam int FEAT_LIM = MAX_FEATURES < FEAT_IDX_LIM ? MAX_FEATURES : FEAT_IDX_LIM;
    localparam logic [CODES_CFG_W-1:0] CODE_LIM_V = CODES_CFG_W'(CODE_LIM);
    localparam logic [FEATS_CFG_W-1:0] FEAT_LIM_V = FEATS_CFG_W'(FEAT_LIM);

    logic [CODES_CFG_W-1:0] r_codes;
    logic [FEATS_CFG_W-1:0] r_feats;
    logic [CODES_CFG_W-1:0] w_nc;
    logic [FEATS_CFG_W-1:0] w_nf;

    logic                w_push;
    t_cmd                w_push_cmd;
    logic                w_fifo_full;
    logic                w_pop;
    t_cmd                w_head_cmd;
    logic                w_cmd_avail;
    logic                w_res_valid;
    logic [CODE_W-1:0]   w_res_code;
    logic [SUM_BITS-1:0] w_res_sum;
    logic                w_sq_ready;
    logic                w_sq_done;
    logic [CODE_W-1:0]   w_sq_code;
    logic [DIST_W-1:0]   w_sq_root;
    logic                w_load;

    logic r_o_valid;
    t_out r_o_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes <= CODES_RESET;
            r_feats <= FEATS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CODES: r_codes <= i_cfg_data[CODES_CFG_W-1:0];
                CFG_FEATS: r_feats <= i_cfg_data[FEATS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // zero counts as one, oversize saturates
    assign w_nc = (r_codes == '0) ? CODES_CFG_W'(1)
                : (r_codes > CODE_LIM_V) ? CODE_LIM_V : r_codes;
    assign w_nf = (r_feats == '0) ? FEATS_CFG_W'(1)
                : (r_feats > FEAT_LIM_V) ? FEAT_LIM_V : r_feats;

    vqnc_front #(
        .MAX_CODES    (MAX_CODES),
        .MAX_FEATURES (MAX_FEATURES)
    ) u_front (
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_feats (w_nf),
        .i_full  (w_fifo_full),
        .o_stall (o_stall),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    vqnc_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_fifo_full),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_avail (w_cmd_avail)
    );

    vqnc_back #(
        .MAX_CODES    (MAX_CODES),
        .MAX_FEATURES (MAX_FEATURES),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .SUM_BITS     (SUM_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_codes     (w_nc),
        .i_feats     (w_nf),
        .i_cmd_avail (w_cmd_avail),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_sq_ready),
        .o_res_code  (w_res_code),
        .o_res_sum   (w_res_sum)
    );

    vqnc_isqrt #(
        .SUM_BITS (SUM_BITS)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_res_valid),
        .i_code  (w_res_code),
        .i_value (w_res_sum),
        .o_ready (w_sq_ready),
        .o_done  (w_sq_done),
        .o_code  (w_sq_code),
        .o_root  (w_sq_root),
        .i_take  (w_load)
    );

    // output register: load when empty or being drained this cycle
    assign w_load = w_sq_done && (!r_o_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_data.best_code <= w_sq_code;
            r_o_data.distance  <= w_sq_root;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_fifo_full)
        else $error("command pushed into a full queue");

    a_pop_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_cmd_avail)
        else $error("command popped from an empty queue");

    a_sqrt_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid && w_sq_ready |=> !w_sq_ready)
        else $error("square root unit did not take the search result");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_done && !r_o_valid |=> r_o_valid && !w_sq_done)
        else $error("finished result not moved into the output register");
`endif

endmodule

/* rtl/vqnc_ram.sv */
// ----------------------------------------------------------------------------
// vqnc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vqnc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/vqnc_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// vqnc_cmd_fifo
// Short command queue between the classifying front part and the back part.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vqnc_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vqnc_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output vqnc_pkg::t_cmd o_cmd,
    output logic           o_avail
);
    import vqnc_pkg::*;

    localparam int PW = $clog2(CMD_FIFO_DEPTH);

    t_cmd          r_mem [CMD_FIFO_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (PW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (PW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_full  = (r_cnt == (PW+1)'(CMD_FIFO_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

endmodule

/* rtl/vqnc_front.sv */
// ----------------------------------------------------------------------------
// vqnc_front
// Input acceptance: range checks, search trigger detection, queue push.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vqnc_front #(
    parameter int MAX_CODES    = 256,
    parameter int MAX_FEATURES = 16
) (
    input  logic                                i_valid,
    input  vqnc_pkg::t_in                       i_data,
    input  logic [vqnc_pkg::FEATS_CFG_W-1:0]    i_feats,
    input  logic                                i_full,
    output logic                                o_stall,
    output logic                                o_push,
    output vqnc_pkg::t_cmd                      o_cmd
);
    import vqnc_pkg::*;

    logic w_code_ok;
    logic w_feat_ok;
    logic w_keep;
    logic w_last;

    assign w_code_ok = int'(i_data.code_index) < MAX_CODES;
    assign w_feat_ok = int'(i_data.feature_index) < MAX_FEATURES;
    assign w_last    = ({1'b0, i_data.feature_index} == (i_feats - 5'd1));

    always_comb begin
        o_cmd.code_index    = i_data.code_index;
        o_cmd.feature_index = i_data.feature_index;
        o_cmd.sample_value  = i_data.sample_value;
        if (i_data.op == OP_CODE_WR) begin
            w_keep     = w_code_ok && w_feat_ok;
            o_cmd.kind = KIND_CODE_WR;
        end else begin
            // a feature past the count is stored but starts no search
            w_keep     = w_feat_ok;
            o_cmd.kind = w_last ? KIND_SEARCH : KIND_OBS;
        end
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full && w_keep;

endmodule

/* rtl/vqnc_isqrt.sv */
// ----------------------------------------------------------------------------
// vqnc_isqrt
// Bit-serial floor square root, one result bit per cycle, saturated output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vqnc_isqrt #(
    parameter int SUM_BITS = 36
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [vqnc_pkg::CODE_W-1:0]   i_code,
    input  logic [SUM_BITS-1:0]           i_value,
    output logic                          o_ready,
    output logic                          o_done,
    output logic [vqnc_pkg::CODE_W-1:0]   o_code,
    output logic [vqnc_pkg::DIST_W-1:0]   o_root,
    input  logic                          i_take
);
    import vqnc_pkg::*;

    localparam int ROOT_BITS = (SUM_BITS + 1) / 2;
    localparam int PAD_BITS  = 2 * ROOT_BITS;
    localparam int RW        = ROOT_BITS + 2;
    localparam int CW        = $clog2(ROOT_BITS + 1);

    localparam logic [1:0] SQ_IDLE = 2'd0;
    localparam logic [1:0] SQ_BUSY = 2'd1;
    localparam logic [1:0] SQ_DONE = 2'd2;

    logic [1:0]           r_state;
    logic [PAD_BITS-1:0]  r_x;
    logic [RW-1:0]        r_rem;
    logic [ROOT_BITS-1:0] r_root;
    logic [CW-1:0]        r_cnt;
    logic [CODE_W-1:0]    r_code;

    logic [RW-1:0] w_rem_sh;
    logic [RW-1:0] w_trial;
    logic          w_fit;

    assign w_rem_sh = {r_rem[RW-3:0], r_x[PAD_BITS-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_fit    = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
        end else begin
            unique case (r_state)
                SQ_IDLE: if (i_start) r_state <= SQ_BUSY;
                SQ_BUSY: if (r_cnt == CW'(ROOT_BITS - 1)) r_state <= SQ_DONE;
                SQ_DONE: if (i_take) r_state <= SQ_IDLE;
                default: r_state <= SQ_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == SQ_IDLE && i_start) begin
            r_x    <= PAD_BITS'(i_value);
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
            r_code <= i_code;
        end else if (r_state == SQ_BUSY) begin
            r_x    <= {r_x[PAD_BITS-3:0], 2'b00};
            r_rem  <= w_fit ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[ROOT_BITS-2:0], w_fit};
            r_cnt  <= r_cnt + CW'(1);
        end
    end

    generate
        if (ROOT_BITS > DIST_W) begin : g_sat
            assign o_root = (|r_root[ROOT_BITS-1:DIST_W]) ? {DIST_W{1'b1}}
                                                           : r_root[DIST_W-1:0];
        end else begin : g_nosat
            assign o_root = DIST_W'(r_root);
        end
    endgenerate

    assign o_ready = (r_state == SQ_IDLE);
    assign o_done  = (r_state == SQ_DONE);
    assign o_code  = r_code;

endmodule

/* rtl/vqnc_back.sv */
// ----------------------------------------------------------------------------
// vqnc_back
// Command execution: codebook and observation writes, and the nearest-code
// search through one pipelined multiply-accumulate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vqnc_back #(
    parameter int MAX_CODES    = 256,
    parameter int MAX_FEATURES = 16,
    parameter int SAMPLE_BITS  = 16,
    parameter int SUM_BITS     = 36
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [vqnc_pkg::CODES_CFG_W-1:0]    i_codes,
    input  logic [vqnc_pkg::FEATS_CFG_W-1:0]    i_feats,
    input  logic                                i_cmd_avail,
    input  vqnc_pkg::t_cmd                      i_cmd,
    output logic                                o_pop,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic [vqnc_pkg::CODE_W-1:0]         o_res_code,
    output logic [SUM_BITS-1:0]                 o_res_sum
);
    import vqnc_pkg::*;

    localparam int S         = SAMPLE_BITS;
    localparam int DEPTH     = MAX_CODES * MAX_FEATURES;
    localparam int AW        = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int OBS_DEPTH = MAX_FEATURES < FEAT_IDX_LIM ? MAX_FEATURES : FEAT_IDX_LIM;
    localparam int OW        = OBS_DEPTH > 1 ? $clog2(OBS_DEPTH) : 1;
    localparam int ACC_BITS  = 2 * S + 4;
    localparam int CCW       = CODES_CFG_W;
    localparam logic [AW-1:0] STRIDE = AW'(MAX_FEATURES);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_HAND  = 2'd3;

    logic [1:0] r_state;

    // observation buffer
    logic [S-1:0] r_obs [OBS_DEPTH];

    // search counters
    logic [OW-1:0]  r_fcnt;
    logic [CCW-1:0] r_ccnt;
    logic [AW-1:0]  r_base;

    // pipeline
    logic           r_p1_v, r_p1_first, r_p1_last;
    logic [CCW-1:0] r_p1_code;
    logic [S-1:0]   r_p1_obs;
    logic           r_p2_v, r_p2_first, r_p2_last;
    logic [CCW-1:0] r_p2_code;
    logic [S-1:0]   r_abs;
    logic           r_p3_v, r_p3_first, r_p3_last;
    logic [CCW-1:0] r_p3_code;
    logic [2*S-1:0] r_sq;
    logic           r_p4_v;
    logic [CCW-1:0] r_p4_code;
    logic [ACC_BITS-1:0] r_acc;
    logic [CCW-1:0] r_best_code;
    logic [SUM_BITS-1:0] r_best_sum;

    logic [S-1:0]        w_samp;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [AW-1:0]       w_raddr;
    logic [S-1:0]        w_rdata;
    logic                w_flast;
    logic                w_clast;
    logic [S:0]          w_diff;
    logic [S:0]          w_mag;
    logic [SUM_BITS-1:0] w_sum_sat;
    logic                w_pipe_busy;

    // sample taken from the low bits of the field, zero-filled when wider
    generate
        if (S <= SAMPLE_W) begin : g_narrow
            assign w_samp = i_cmd.sample_value[S-1:0];
        end else begin : g_wide
            assign w_samp = {{(S - SAMPLE_W){1'b0}}, i_cmd.sample_value};
        end
    endgenerate

    assign o_pop   = (r_state == ST_IDLE) && i_cmd_avail;
    assign w_we    = o_pop && (i_cmd.kind == KIND_CODE_WR);
    assign w_waddr = AW'(i_cmd.code_index) * STRIDE + AW'(i_cmd.feature_index);
    assign w_raddr = r_base + AW'(r_fcnt);
    assign w_flast = (r_fcnt == OW'(i_feats - 5'd1));
    assign w_clast = (r_ccnt == (i_codes - CCW'(1)));

    vqnc_ram #(
        .WIDTH (S),
        .DEPTH (DEPTH)
    ) u_codebook (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_samp),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop && i_cmd.kind == KIND_SEARCH) r_state <= ST_ISSUE;
                end
                ST_ISSUE: begin
                    if (w_flast && w_clast) r_state <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    if (!w_pipe_busy) r_state <= ST_HAND;
                end
                ST_HAND: begin
                    if (i_res_ready) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // observation writes and search counters
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            unique case (i_cmd.kind) inside
                KIND_OBS, KIND_SEARCH: r_obs[OW'(i_cmd.feature_index)] <= w_samp;
                default: ;
            endcase
        end
        if (r_state == ST_IDLE) begin
            r_fcnt <= '0;
            r_ccnt <= '0;
            r_base <= '0;
        end else if (r_state == ST_ISSUE) begin
            if (w_flast) begin
                r_fcnt <= '0;
                r_ccnt <= r_ccnt + CCW'(1);
                r_base <= r_base + STRIDE;
            end else begin
                r_fcnt <= r_fcnt + OW'(1);
            end
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
        end else begin
            r_p1_v <= (r_state == ST_ISSUE);
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v && r_p3_last;
        end
    end

    assign w_pipe_busy = r_p1_v || r_p2_v || r_p3_v || r_p4_v;

    assign w_diff = {w_rdata[S-1], w_rdata} - {r_p1_obs[S-1], r_p1_obs};
    assign w_mag  = w_diff[S] ? (~w_diff + (S+1)'(1)) : w_diff;

    generate
        if (ACC_BITS > SUM_BITS) begin : g_sat
            assign w_sum_sat = (|r_acc[ACC_BITS-1:SUM_BITS]) ? {SUM_BITS{1'b1}}
                                                             : r_acc[SUM_BITS-1:0];
        end else begin : g_nosat
            assign w_sum_sat = SUM_BITS'(r_acc);
        end
    endgenerate

    // pipeline payload
    always_ff @(posedge i_clk) begin
        // read issue: codebook read in flight, buffer sample alongside
        r_p1_first <= (r_fcnt == '0);
        r_p1_last  <= w_flast;
        r_p1_code  <= r_ccnt;
        r_p1_obs   <= r_obs[r_fcnt];
        // difference magnitude
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        r_p2_code  <= r_p1_code;
        r_abs      <= w_mag[S-1:0];
        // square
        r_p3_first <= r_p2_first;
        r_p3_last  <= r_p2_last;
        r_p3_code  <= r_p2_code;
        r_sq       <= r_abs * r_abs;
        // accumulate per code
        if (r_p3_v) begin
            r_acc <= (r_p3_first ? {ACC_BITS{1'b0}} : r_acc) + ACC_BITS'(r_sq);
        end
        r_p4_code <= r_p3_code;
        // keep the first code at the minimum
        if (r_p4_v && (r_p4_code == '0 || w_sum_sat < r_best_sum)) begin
            r_best_code <= r_p4_code;
            r_best_sum  <= w_sum_sat;
        end
    end

    assign o_res_valid = (r_state == ST_HAND);
    assign o_res_code  = r_best_code[CODE_W-1:0];
    assign o_res_sum   = r_best_sum;

endmodule

/* sim/tb_vector_quantizer_nearest_code_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_quantizer_nearest_code_unit
// Self-checking bench for the nearest-code vector quantiser. The bench
// tracks the codebook, the observation buffer and both registers, works out
// the winning code and the floor root of its distance for every search, and
// matches each result transaction against the oldest outstanding one. It
// steps through several register settings and pacing patterns on both
// channels.
// ----------------------------------------------------------------------------

module tb_vector_quantizer_nearest_code_unit;

    import vqnc_pkg::*;

    localparam int     CODES_LIM     = 256;
    localparam int     FEATS_LIM     = 16;
    localparam int     SETTLE_CYCLES = 32;
    localparam int     HOLD_CYCLES   = 400;
    // Worst case: every transaction a 256-code search plus long stalls,
    // taken several times over.
    localparam longint LIMIT_NS      = 64'd500_000_000;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;

    typedef enum int {PACE_FULL, PACE_TX_IDLE, PACE_RX_STALL, PACE_BOTH} t_pace;

    // ------------------------------------------------------------------------
    // Tracks codebook, observation buffer and registers; holds the searches
    // still waiting for their result transaction.
    // ------------------------------------------------------------------------
    class nearest_code_board;
        logic signed [SAMPLE_W-1:0] codebook [CODES_LIM][FEATS_LIM];
        logic signed [SAMPLE_W-1:0] observation [FEATS_LIM];
        bit                         cb_written [CODES_LIM][FEATS_LIM];
        bit                         obs_written [FEATS_LIM];
        logic [CODES_CFG_W-1:0]     codes_raw;
        logic [FEATS_CFG_W-1:0]     feats_raw;
        t_out                       awaited_matches [$];
        int                         fault_count;

        function new();
            codes_raw   = CODES_RESET;
            feats_raw   = FEATS_RESET;
            fault_count = 0;
        endfunction

        function int codes_used();
            if (codes_raw == 0) return 1;
            if (codes_raw > CODES_LIM) return CODES_LIM;
            return int'(codes_raw);
        endfunction

        function int feats_used();
            if (feats_raw == 0) return 1;
            if (feats_raw > FEATS_LIM) return FEATS_LIM;
            return int'(feats_raw);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_CODES) codes_raw = val[CODES_CFG_W-1:0];
            else                  feats_raw = val[FEATS_CFG_W-1:0];
        endfunction

        function longint unsigned floor_root(longint unsigned v);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= v) r = t;
            end
            if (r > 64'd262143) r = 64'd262143;
            return r;
        endfunction

        // Apply one accepted input transaction; queue a result when it
        // completes an observation.
        function void record_sample(t_in item);
            int              nc;
            int              nf;
            int              best;
            longint          d;
            longint unsigned sum;
            longint unsigned best_sum;
            t_out            res;
            if (item.op == OP_CODE_WR) begin
                codebook[item.code_index][item.feature_index]   = item.sample_value;
                cb_written[item.code_index][item.feature_index] = 1'b1;
                return;
            end
            observation[item.feature_index] = item.sample_value;
            obs_written[item.feature_index] = 1'b1;
            nf = feats_used();
            if (int'(item.feature_index) != nf - 1) return;
            nc       = codes_used();
            best     = 0;
            best_sum = '1;
            // Sums never reach saturation at 16-bit samples
            for (int c = 0; c < nc; c++) begin
                sum = 0;
                for (int f = 0; f < nf; f++) begin
                    d   = longint'(codebook[c][f]) - longint'(observation[f]);
                    sum = sum + longint'(d * d);
                end
                if (c == 0 || sum < best_sum) begin
                    best     = c;
                    best_sum = sum;
                end
            end
            res.best_code = best[CODE_W-1:0];
            res.distance  = DIST_W'(floor_root(best_sum));
            awaited_matches.push_back(res);
        endfunction

        function void check_match(t_out got);
            t_out exp;
            if (awaited_matches.size() == 0) begin
                $display("%0t: result with none outstanding: best_code %0d distance %0d",
                         $time, got.best_code, got.distance);
                fault_count++;
                return;
            end
            exp = awaited_matches.pop_front();
            if (got.best_code !== exp.best_code) begin
                $display("%0t: best_code expected %0d actual %0d",
                         $time, exp.best_code, got.best_code);
                fault_count++;
            end
            if (got.distance !== exp.distance) begin
                $display("%0t: distance expected %0d actual %0d",
                         $time, exp.distance, got.distance);
                fault_count++;
            end
        endfunction

        function int pending();
            return awaited_matches.size();
        endfunction

        function void close_out();
            if (awaited_matches.size() != 0) begin
                $display("%0t: %0d results never arrived", $time, awaited_matches.size());
                fault_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    t_in                    i_data;
    logic                   o_valid;
    logic                   i_stall;
    t_out                   o_data;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    nearest_code_board sb;
    int                tx_idle_pct  = 0;
    int                rx_stall_pct = 0;
    bit                hold_request = 1'b0;

    always #5 i_clk = ~i_clk;

    vector_quantizer_nearest_code_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Receiver: check the transaction taken at this edge (pre-edge values),
    // then choose the stall for the next cycle. A hold request keeps the
    // output stalled for a long stretch so the input queue backs up.
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
                sb.check_match(o_data);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    // Hard stop in case the block hangs
    initial begin
        #(LIMIT_NS);
        $display("tb_vector_quantizer_nearest_code_unit: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_in make_item(logic op, int code, int feat,
                                      logic signed [SAMPLE_W-1:0] v);
        t_in item;
        item.op            = op;
        item.code_index    = code[CODE_W-1:0];
        item.feature_index = feat[FIDX_W-1:0];
        item.sample_value  = v;
        return item;
    endfunction

    // Full range, a narrow band round zero (ties, exact hits) or the extremes
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(int style);
        case (style)
            0: begin
                return SAMPLE_W'($urandom);
            end
            1: begin
                return SAMPLE_W'($urandom_range(8)) - 16'sd4;
            end
            default: begin
                case ($urandom_range(3))
                    0:       return SAMPLE_MIN;
                    1:       return SAMPLE_MAX;
                    2:       return 16'sd0;
                    default: return -16'sd1;
                endcase
            end
        endcase
    endfunction

    task automatic set_pace(input t_pace pace);
        case (pace)
            PACE_FULL: begin
                tx_idle_pct = 0;  rx_stall_pct = 0;
            end
            PACE_TX_IDLE: begin
                tx_idle_pct = 75; rx_stall_pct = 0;
            end
            PACE_RX_STALL: begin
                tx_idle_pct = 0;  rx_stall_pct = 75;
            end
            default: begin
                tx_idle_pct = 15; rx_stall_pct = 15;
            end
        endcase
    endtask

    // Offer one input transaction, with a random gap first, and hold it
    // until the block takes it.
    task automatic offer(input t_in item);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (o_stall);
        sb.record_sample(item);
    endtask

    task automatic write_code(input int code, input int feat,
                              input logic signed [SAMPLE_W-1:0] v);
        offer(make_item(OP_CODE_WR, code, feat, v));
    endtask

    task automatic observe(input int feat, input logic signed [SAMPLE_W-1:0] v);
        offer(make_item(OP_OBSERVE, $urandom_range(255), feat, v));
    endtask

    // Drop valid and wait for every outstanding result; optionally let the
    // queue finish any transactions that produce no result.
    task automatic wait_drained(input bit settle);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers, only once the block is idle
    task automatic program_regs(input logic [CFG_DATA_W-1:0] codes_val,
                                input logic [CFG_DATA_W-1:0] feats_val);
        wait_drained(1'b1);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_CODES;
        i_cfg_data  <= codes_val;
        @(posedge i_clk);
        sb.write_reg(CFG_CODES, codes_val);
        i_cfg_index <= CFG_FEATS;
        i_cfg_data  <= feats_val;
        @(posedge i_clk);
        sb.write_reg(CFG_FEATS, feats_val);
        i_cfg_we    <= 1'b0;
    endtask

    // Fill every codebook entry and observation slot the next search can
    // read, so no search ever touches a slot that was never written.
    task automatic prime_for_search();
        int nc;
        int nf;
        nc = sb.codes_used();
        nf = sb.feats_used();
        for (int c = 0; c < nc; c++) begin
            for (int f = 0; f < nf; f++) begin
                if (!sb.cb_written[c][f]) write_code(c, f, pick_sample($urandom_range(2)));
            end
        end
        for (int f = 0; f < nf - 1; f++) begin
            if (!sb.obs_written[f]) observe(f, pick_sample($urandom_range(2)));
        end
    endtask

    // Mostly complete observations with random content, some codebook
    // bursts, some truncated observations and raw noise.
    task automatic run_random(input int count);
        int   sent;
        int   pick;
        int   style;
        int   nc;
        int   nf;
        int   cut;
        t_in  item;
        sent = 0;
        nc   = sb.codes_used();
        nf   = sb.feats_used();
        while (sent < count) begin
            pick  = $urandom_range(99);
            style = $urandom_range(2);
            if (pick < 60) begin
                // truncated in one case of ten: no search
                cut = ($urandom_range(9) == 0) ? $urandom_range(nf - 1) : nf;
                for (int f = 0; f < cut; f++) begin
                    observe(f, pick_sample(style));
                    sent++;
                end
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 4)) begin
                    write_code(($urandom_range(3) == 0) ? $urandom_range(255)
                                                        : $urandom_range(nc - 1),
                               ($urandom_range(3) == 0) ? $urandom_range(15)
                                                        : $urandom_range(nf - 1),
                               pick_sample(style));
                    sent++;
                end
            end else if (pick < 98) begin
                item.op            = 1'($urandom);
                item.code_index    = CODE_W'($urandom);
                item.feature_index = FIDX_W'($urandom);
                item.sample_value  = SAMPLE_W'($urandom);
                offer(item);
                sent++;
            end else begin
                wait_drained(1'b0);
            end
        end
    endtask

    task automatic run_phase(input t_pace pace, input int count);
        set_pace(pace);
        prime_for_search();
        run_random(count);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_CODES;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Three codes of two features: opposite corners, and a duplicate of
        // code one to show the earlier code winning a tie.
        set_pace(PACE_FULL);
        program_regs(9'd3, 9'd2);
        write_code(0, 0, SAMPLE_MIN);
        write_code(0, 1, SAMPLE_MIN);
        write_code(1, 0, SAMPLE_MAX);
        write_code(1, 1, SAMPLE_MAX);
        write_code(2, 0, SAMPLE_MAX);
        write_code(2, 1, SAMPLE_MAX);
        write_code(255, 15, 16'sh5555);
        write_code(170, 10, 16'shAAAA);
        observe(15, 16'sd0);           // past the feature count: stored only
        observe(0, SAMPLE_MAX);
        observe(1, SAMPLE_MAX);        // exact hit on codes one and two
        observe(1, SAMPLE_MIN);        // equal distance to codes zero and one
        observe(0, SAMPLE_MIN);
        observe(1, SAMPLE_MIN);        // exact hit on code zero
        observe(1, 16'sd0);

        run_phase(PACE_FULL, 200);

        // Zero code count reads as one; oversized feature count saturates
        // to sixteen. Opposite extremes on every feature give the largest
        // distance.
        program_regs(9'd0, 9'h1FF);
        set_pace(PACE_TX_IDLE);
        for (int f = 0; f < FEATS_LIM; f++) write_code(0, f, SAMPLE_MIN);
        for (int f = 0; f < FEATS_LIM; f++) observe(f, SAMPLE_MAX);
        run_phase(PACE_TX_IDLE, 150);

        // Oversized code count saturates to the full codebook; zero
        // feature count reads as one.
        program_regs(9'h1FF, 9'd0);
        run_phase(PACE_RX_STALL, 150);

        program_regs(9'd16, 9'd8);
        run_phase(PACE_BOTH, 200);

        // Back-pressure: hold the output while searches keep arriving, so
        // the queue fills and the input stalls; halfway through, pause
        // until every result is in.
        program_regs(9'd5, 9'd2);
        set_pace(PACE_FULL);
        prime_for_search();
        hold_request = 1'b1;
        for (int k = 0; k < 30; k++) begin
            if (k == 15) wait_drained(1'b0);
            observe(0, pick_sample($urandom_range(2)));
            observe(1, pick_sample($urandom_range(2)));
        end

        program_regs(9'd7, 9'd5);
        run_phase(PACE_FULL, 200);

        program_regs(9'd2, 9'd16);
        run_phase(PACE_TX_IDLE, 200);

        program_regs(9'd33, 9'd3);
        run_phase(PACE_RX_STALL, 200);

        program_regs(9'd3, 9'd6);
        run_phase(PACE_BOTH, 150);

        wait_drained(1'b1);
        sb.close_out();
        if (sb.fault_count == 0) begin
            $display("tb_vector_quantizer_nearest_code_unit: done, clean");
        end else begin
            $display("tb_vector_quantizer_nearest_code_unit: done, errors");
        end
        $finish;
    end

endmodule
